@@ hw/rtl/csp_pkg.sv @@
// shared widths, constants and controller/datapath types for the position/speed servo
package csp_pkg;

    // widths of stored and working values
    localparam int CNT_W     = 16;
    localparam int POS_W     = 32;
    localparam int ERR_W     = 33;
    localparam int GAIN_W    = 24;
    localparam int DB_W      = 16;
    localparam int BASE_W    = 10;
    localparam int DUTY_W    = 10;
    localparam int SPD_W     = 27;
    localparam int TGT_W     = 18;
    localparam int PINT_W    = 13;
    localparam int SINT_W    = 18;
    localparam int E_W       = 28;
    localparam int DD_W      = 30;
    localparam int ACC_W     = 58;
    localparam int MA_W      = 25;
    localparam int MB_W      = 33;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int X_W       = 22;
    localparam int SMAG_W    = 26;
    localparam int TMAG_W    = 17;
    localparam int Q_W       = 14;

    // speed = delta * 384000 / 209, split as delta*1837 + (delta*67 + 104) / 209
    localparam logic [SMAG_W-1:0] SPD_MUL_INT  = SMAG_W'(1837);
    localparam logic [X_W-1:0]    SPD_MUL_REM  = X_W'(67);
    localparam logic [X_W-1:0]    SPD_DEN_HALF = X_W'(104);
    // ceil(2^30 / 209), exact floor for every remainder term
    localparam logic [MA_W-1:0]   SPD_RECIP    = MA_W'(5137521);
    localparam int                SPD_RECIP_SH = 30;
    localparam logic [SMAG_W-1:0] SPEED_SAT    = SMAG_W'(60300000);

    localparam logic [TMAG_W-1:0] TARGET_SAT   = TMAG_W'(76800);
    localparam logic [TMAG_W-1:0] HALF_RPM     = TMAG_W'(128);
    localparam logic [ACC_W-1:0]  TGT_ROUND    = ACC_W'(128);
    localparam int                TGT_SHIFT    = 8;
    localparam int                POS_INT_SAT  = 3000;
    localparam int                SINT_HIGH    = 128000;
    localparam int                SINT_LOW     = -25600;
    localparam logic [DUTY_W-1:0] DUTY_MIN     = DUTY_W'(50);
    localparam logic [DUTY_W-1:0] DUTY_MAX     = DUTY_W'(900);
    localparam int                DUTY_FRAC    = 24;

    // register reset values
    localparam logic [POS_W-1:0]  RST_TARGET   = POS_W'(500);
    localparam logic [GAIN_W-1:0] RST_POS_KP   = GAIN_W'(52429);
    localparam logic [GAIN_W-1:0] RST_POS_KI   = GAIN_W'(328);
    localparam logic [DB_W-1:0]   RST_DEADBAND = DB_W'(8);
    localparam logic [GAIN_W-1:0] RST_SPD_KP   = GAIN_W'(294912);
    localparam logic [GAIN_W-1:0] RST_SPD_KI   = GAIN_W'(29491);
    localparam logic [GAIN_W-1:0] RST_SPD_KD   = GAIN_W'(9830);
    localparam logic [BASE_W-1:0] RST_BASE     = BASE_W'(650);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET_POSITION = 3'd0,
        REG_POSITION_KP     = 3'd1,
        REG_POSITION_KI     = 3'd2,
        REG_DEADBAND_COUNTS = 3'd3,
        REG_SPEED_KP        = 3'd4,
        REG_SPEED_KI        = 3'd5,
        REG_SPEED_KD        = 3'd6,
        REG_DUTY_BASE       = 3'd7
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DIFF, ST_SPD, ST_SPD2, ST_PINT, ST_PKI, ST_PSUM, ST_ABS,
        ST_TGT, ST_E, ST_SKP, ST_SKI, ST_SKD, ST_SACC, ST_DUTY, ST_DONE
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE, OP_DIFF, OP_SPD, OP_SPD2, OP_PINT, OP_PKI, OP_PSUM, OP_ABS,
        OP_TGT, OP_E, OP_SKP, OP_SKI, OP_SKD, OP_SACC, OP_DUTY
    } t_op;

    typedef struct packed {
        t_op  op;
        logic load;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic dead;
        logic run;
    } t_status;

endpackage

@@ hw/rtl/csp_dp.sv @@
// datapath of the servo: registers, loop state, shared multiplier and result word register
module csp_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [csp_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [csp_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic [csp_pkg::CNT_W-1:0]         i_encoder_count,
    input  csp_pkg::t_cmd                     i_cmd,
    output csp_pkg::t_status                  o_status,
    output logic [csp_pkg::DUTY_W-1:0]        o_pwm_duty,
    output logic                              o_dir_a,
    output logic                              o_dir_b,
    output logic signed [csp_pkg::POS_W-1:0]  o_position_now,
    output logic signed [csp_pkg::SPD_W-1:0]  o_speed_now,
    output logic signed [csp_pkg::TGT_W-1:0]  o_speed_target,
    output logic                              o_in_deadband
);

    localparam int CW  = csp_pkg::CNT_W;
    localparam int PW  = csp_pkg::POS_W;
    localparam int EW  = csp_pkg::ERR_W;
    localparam int XW  = csp_pkg::X_W;
    localparam int SW  = csp_pkg::SMAG_W;
    localparam int TW  = csp_pkg::TMAG_W;
    localparam int AW  = csp_pkg::ACC_W;
    localparam int BW  = csp_pkg::MB_W;
    localparam int IW  = csp_pkg::PINT_W;
    localparam int NW  = csp_pkg::SINT_W;
    localparam int VW  = csp_pkg::E_W;
    localparam int DW  = csp_pkg::DD_W;
    localparam int PSW = EW + 1;
    localparam int NSW = VW + 1;
    localparam int TQW = AW - csp_pkg::TGT_SHIFT;

    localparam logic signed [PSW-1:0] PINT_HI = PSW'(csp_pkg::POS_INT_SAT);
    localparam logic signed [PSW-1:0] PINT_LO = PSW'(-csp_pkg::POS_INT_SAT);
    localparam logic signed [NSW-1:0] SINT_HI = NSW'(csp_pkg::SINT_HIGH);
    localparam logic signed [NSW-1:0] SINT_LO = NSW'(csp_pkg::SINT_LOW);
    localparam logic signed [AW-1:0]  DUTY_LO_Q =
        $signed({{(AW-csp_pkg::DUTY_W){1'b0}}, csp_pkg::DUTY_MIN}) <<< csp_pkg::DUTY_FRAC;
    localparam logic signed [AW-1:0]  DUTY_HI_Q =
        $signed({{(AW-csp_pkg::DUTY_W){1'b0}}, csp_pkg::DUTY_MAX}) <<< csp_pkg::DUTY_FRAC;

    // configuration registers
    logic signed [PW-1:0]              r_target;
    logic [csp_pkg::GAIN_W-1:0]        r_pos_kp, r_pos_ki, r_spd_kp, r_spd_ki, r_spd_kd;
    logic [csp_pkg::DB_W-1:0]          r_db;
    logic [csp_pkg::BASE_W-1:0]        r_base;

    // loop state
    logic [CW-1:0]                     r_prev;
    logic signed [PW-1:0]              r_pos;
    logic signed [IW-1:0]              r_pint;
    logic signed [NW-1:0]              r_sint;
    logic signed [VW-1:0]              r_e1, r_e2;
    logic                              r_pin_a, r_pin_b;

    // working registers
    logic [CW-1:0]                     r_cnt;
    logic                              r_dneg;
    logic [XW-1:0]                     r_x;
    logic [SW-1:0]                     r_sbase;
    logic signed [AW-1:0]              r_prod;
    logic signed [AW-1:0]              r_acc;
    logic signed [EW-1:0]              r_err;
    logic                              r_dead;
    logic [SW-1:0]                     r_smag;
    logic signed [csp_pkg::SPD_W-1:0]  r_speed;
    logic                              r_tneg;
    logic [TW-1:0]                     r_tmag;
    logic                              r_run;
    logic signed [csp_pkg::TGT_W-1:0]  r_tgt;
    logic signed [VW-1:0]              r_e;
    logic signed [DW-1:0]              r_dd;
    logic [csp_pkg::DUTY_W-1:0]        r_duty;

    // result word register
    logic [csp_pkg::DUTY_W-1:0]        r_o_duty;
    logic                              r_o_dir_a, r_o_dir_b;
    logic signed [PW-1:0]              r_o_pos;
    logic signed [csp_pkg::SPD_W-1:0]  r_o_speed;
    logic signed [csp_pkg::TGT_W-1:0]  r_o_tgt;
    logic                              r_o_dead;

    // combinational terms
    logic [CW-1:0]                     d_raw;
    logic [CW-1:0]                     adelta;
    logic [XW-1:0]                     x_val;
    logic [SW-1:0]                     sbase_val;
    logic signed [PW:0]                pos_sum;
    logic signed [PW-1:0]              pos_next;
    logic signed [EW-1:0]              err_val;
    logic [csp_pkg::Q_W-1:0]           q_val;
    logic [SW-1:0]                     smag_sum;
    logic [SW-1:0]                     smag_val;
    logic signed [csp_pkg::SPD_W-1:0]  speed_val;
    logic [EW-1:0]                     aerr;
    logic                              dead_val;
    logic signed [PSW-1:0]             pint_sum;
    logic signed [IW-1:0]              pint_next;
    logic signed [AW-1:0]              acc_abs;
    logic [AW-1:0]                     t_round;
    logic [TQW-1:0]                    t_quot;
    logic [TW-1:0]                     tmag_val;
    logic signed [csp_pkg::TGT_W-1:0]  tgt_val;
    logic signed [VW-1:0]              e_val;
    logic signed [NSW-1:0]             sint_sum;
    logic signed [NW-1:0]              sint_next;
    logic signed [DW-1:0]              dd_val;
    logic [csp_pkg::DUTY_W-1:0]        duty_val;
    logic signed [csp_pkg::MA_W-1:0]   mul_a;
    logic signed [BW-1:0]              mul_b;
    logic signed [AW-1:0]              mul_p;

    // counter difference, wrapped
    assign d_raw     = r_cnt - r_prev;
    assign adelta    = d_raw[CW-1] ? (~d_raw + CW'(1)) : d_raw;
    assign x_val     = {{(XW-CW){1'b0}}, adelta} * csp_pkg::SPD_MUL_REM + csp_pkg::SPD_DEN_HALF;
    assign sbase_val = {{(SW-CW){1'b0}}, adelta} * csp_pkg::SPD_MUL_INT;

    // saturating position accumulate
    assign pos_sum  = $signed({r_pos[PW-1], r_pos})
                    + $signed({{(PW+1-CW){d_raw[CW-1]}}, d_raw});
    assign pos_next = (pos_sum[PW] != pos_sum[PW-1])
                    ? (pos_sum[PW] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}})
                    : pos_sum[PW-1:0];

    assign err_val = $signed({r_target[PW-1], r_target}) - $signed({r_pos[PW-1], r_pos});

    // measured speed magnitude and sign
    assign q_val     = r_prod[csp_pkg::SPD_RECIP_SH +: csp_pkg::Q_W];
    assign smag_sum  = r_sbase + {{(SW-csp_pkg::Q_W){1'b0}}, q_val};
    assign smag_val  = (smag_sum > csp_pkg::SPEED_SAT) ? csp_pkg::SPEED_SAT : smag_sum;
    assign speed_val = r_dneg ? -$signed({1'b0, smag_val}) : $signed({1'b0, smag_val});

    assign aerr     = r_err[EW-1] ? -r_err : r_err;
    assign dead_val = aerr < {{(EW-csp_pkg::DB_W){1'b0}}, r_db};

    assign pint_sum  = $signed({{(PSW-IW){r_pint[IW-1]}}, r_pint})
                     + $signed({r_err[EW-1], r_err});
    assign pint_next = (pint_sum > PINT_HI) ? PINT_HI[IW-1:0]
                     : (pint_sum < PINT_LO) ? PINT_LO[IW-1:0]
                     : pint_sum[IW-1:0];

    // speed demand: round half away from zero on the magnitude, then clamp
    assign acc_abs  = r_acc[AW-1] ? -r_acc : r_acc;
    assign t_round  = r_acc + csp_pkg::TGT_ROUND;
    assign t_quot   = t_round[AW-1:csp_pkg::TGT_SHIFT];
    assign tmag_val = (t_quot > {{(TQW-TW){1'b0}}, csp_pkg::TARGET_SAT})
                    ? csp_pkg::TARGET_SAT : t_quot[TW-1:0];
    assign tgt_val  = r_tneg ? -$signed({1'b0, tmag_val}) : $signed({1'b0, tmag_val});

    assign e_val = $signed({{(VW-TW){1'b0}}, r_tmag}) - $signed({{(VW-SW){1'b0}}, r_smag});

    assign sint_sum  = $signed({{(NSW-NW){r_sint[NW-1]}}, r_sint}) + $signed({r_e[VW-1], r_e});
    assign sint_next = (sint_sum > SINT_HI) ? SINT_HI[NW-1:0]
                     : (sint_sum < SINT_LO) ? SINT_LO[NW-1:0]
                     : sint_sum[NW-1:0];

    assign dd_val = $signed({{(DW-VW){r_e[VW-1]}}, r_e})
                  - $signed({{(DW-VW-1){r_e1[VW-1]}}, r_e1, 1'b0})
                  + $signed({{(DW-VW){r_e2[VW-1]}}, r_e2});

    assign duty_val = (r_acc < DUTY_LO_Q) ? csp_pkg::DUTY_MIN
                    : (r_acc > DUTY_HI_Q) ? csp_pkg::DUTY_MAX
                    : r_acc[csp_pkg::DUTY_FRAC +: csp_pkg::DUTY_W];

    // shared multiplier, operands chosen by the current step
    always_comb begin
        unique case (i_cmd.op)
            csp_pkg::OP_SPD: begin
                mul_a = $signed(csp_pkg::SPD_RECIP);
                mul_b = $signed({{(BW-XW){1'b0}}, r_x});
            end
            csp_pkg::OP_SPD2: begin
                mul_a = $signed({1'b0, r_pos_kp});
                mul_b = r_err;
            end
            csp_pkg::OP_PKI: begin
                mul_a = $signed({1'b0, r_pos_ki});
                mul_b = $signed({{(BW-IW){r_pint[IW-1]}}, r_pint});
            end
            csp_pkg::OP_SKP: begin
                mul_a = $signed({1'b0, r_spd_kp});
                mul_b = $signed({{(BW-VW){r_e[VW-1]}}, r_e});
            end
            csp_pkg::OP_SKI: begin
                mul_a = $signed({1'b0, r_spd_ki});
                mul_b = $signed({{(BW-NW){r_sint[NW-1]}}, r_sint});
            end
            csp_pkg::OP_SKD: begin
                mul_a = $signed({1'b0, r_spd_kd});
                mul_b = $signed({{(BW-DW){r_dd[DW-1]}}, r_dd});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // configuration and loop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= csp_pkg::RST_TARGET;
            r_pos_kp <= csp_pkg::RST_POS_KP;
            r_pos_ki <= csp_pkg::RST_POS_KI;
            r_db     <= csp_pkg::RST_DEADBAND;
            r_spd_kp <= csp_pkg::RST_SPD_KP;
            r_spd_ki <= csp_pkg::RST_SPD_KI;
            r_spd_kd <= csp_pkg::RST_SPD_KD;
            r_base   <= csp_pkg::RST_BASE;
            r_prev   <= '0;
            r_pos    <= '0;
            r_pint   <= '0;
            r_sint   <= '0;
            r_e1     <= '0;
            r_e2     <= '0;
            r_pin_a  <= 1'b1;
            r_pin_b  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (csp_pkg::t_cfg_idx'(i_cfg_idx))
                    csp_pkg::REG_TARGET_POSITION: r_target <= $signed(i_cfg_data[PW-1:0]);
                    csp_pkg::REG_POSITION_KP:     r_pos_kp <= i_cfg_data[csp_pkg::GAIN_W-1:0];
                    csp_pkg::REG_POSITION_KI:     r_pos_ki <= i_cfg_data[csp_pkg::GAIN_W-1:0];
                    csp_pkg::REG_DEADBAND_COUNTS: r_db     <= i_cfg_data[csp_pkg::DB_W-1:0];
                    csp_pkg::REG_SPEED_KP:        r_spd_kp <= i_cfg_data[csp_pkg::GAIN_W-1:0];
                    csp_pkg::REG_SPEED_KI:        r_spd_ki <= i_cfg_data[csp_pkg::GAIN_W-1:0];
                    csp_pkg::REG_SPEED_KD:        r_spd_kd <= i_cfg_data[csp_pkg::GAIN_W-1:0];
                    csp_pkg::REG_DUTY_BASE:       r_base   <= i_cfg_data[csp_pkg::BASE_W-1:0];
                endcase
            end
            unique case (i_cmd.op)
                csp_pkg::OP_DIFF: begin
                    r_prev <= r_cnt;
                    r_pos  <= pos_next;
                end
                csp_pkg::OP_PINT: begin
                    r_pint <= r_dead ? '0 : pint_next;
                end
                csp_pkg::OP_E: begin
                    r_pin_a <= ~r_tneg;
                    r_pin_b <= r_tneg;
                end
                csp_pkg::OP_SKP: begin
                    r_sint <= sint_next;
                end
                csp_pkg::OP_SACC: begin
                    r_e2 <= r_e1;
                    r_e1 <= r_e;
                end
                default: ;
            endcase
        end
    end

    // working registers, one step per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cnt <= i_encoder_count;
        end
        unique case (i_cmd.op)
            csp_pkg::OP_DIFF: begin
                r_dneg  <= d_raw[CW-1];
                r_x     <= x_val;
                r_sbase <= sbase_val;
            end
            csp_pkg::OP_SPD: begin
                r_prod <= mul_p;
                r_err  <= err_val;
            end
            csp_pkg::OP_SPD2: begin
                r_smag  <= smag_val;
                r_speed <= speed_val;
                r_dead  <= dead_val;
                r_prod  <= mul_p;
            end
            csp_pkg::OP_PINT: begin
                r_acc <= r_prod;
                if (r_dead) begin
                    r_tgt  <= '0;
                    r_duty <= '0;
                end
            end
            csp_pkg::OP_PKI: begin
                r_prod <= mul_p;
            end
            csp_pkg::OP_PSUM: begin
                r_acc <= r_acc + r_prod;
            end
            csp_pkg::OP_ABS: begin
                r_tneg <= r_acc[AW-1];
                r_acc  <= acc_abs;
            end
            csp_pkg::OP_TGT: begin
                r_tmag <= tmag_val;
                r_run  <= tmag_val > csp_pkg::HALF_RPM;
                r_tgt  <= tgt_val;
                r_duty <= '0;
            end
            csp_pkg::OP_E: begin
                r_e   <= e_val;
                r_acc <= $signed({{(AW-csp_pkg::BASE_W){1'b0}}, r_base}) <<< csp_pkg::DUTY_FRAC;
            end
            csp_pkg::OP_SKP: begin
                r_prod <= mul_p;
                r_dd   <= dd_val;
            end
            csp_pkg::OP_SKI, csp_pkg::OP_SKD: begin
                r_acc  <= r_acc + r_prod;
                r_prod <= mul_p;
            end
            csp_pkg::OP_SACC: begin
                r_acc <= r_acc + r_prod;
            end
            csp_pkg::OP_DUTY: begin
                r_duty <= duty_val;
            end
            default: ;
        endcase
        if (i_cmd.out_load) begin
            r_o_duty  <= r_duty;
            r_o_dir_a <= r_pin_a;
            r_o_dir_b <= r_pin_b;
            r_o_pos   <= r_pos;
            r_o_speed <= r_speed;
            r_o_tgt   <= r_tgt;
            r_o_dead  <= r_dead;
        end
    end

    assign o_status.dead  = r_dead;
    assign o_status.run   = r_run;
    assign o_pwm_duty     = r_o_duty;
    assign o_dir_a        = r_o_dir_a;
    assign o_dir_b        = r_o_dir_b;
    assign o_position_now = r_o_pos;
    assign o_speed_now    = r_o_speed;
    assign o_speed_target = r_o_tgt;
    assign o_in_deadband  = r_o_dead;

endmodule

@@ hw/rtl/csp_ctrl.sv @@
// step sequencer of the servo and the result word valid flag
module csp_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    input  csp_pkg::t_status i_status,
    output csp_pkg::t_cmd    o_cmd
);

    csp_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= csp_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_out_valid  = r_out_valid;
        o_cmd.op       = csp_pkg::OP_NONE;
        o_cmd.load     = 1'b0;
        o_cmd.out_load = 1'b0;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            csp_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = csp_pkg::ST_DIFF;
                end
            end
            csp_pkg::ST_DIFF: begin
                o_cmd.op = csp_pkg::OP_DIFF;
                n_state  = csp_pkg::ST_SPD;
            end
            csp_pkg::ST_SPD: begin
                o_cmd.op = csp_pkg::OP_SPD;
                n_state  = csp_pkg::ST_SPD2;
            end
            csp_pkg::ST_SPD2: begin
                o_cmd.op = csp_pkg::OP_SPD2;
                n_state  = csp_pkg::ST_PINT;
            end
            csp_pkg::ST_PINT: begin
                o_cmd.op = csp_pkg::OP_PINT;
                n_state  = i_status.dead ? csp_pkg::ST_DONE : csp_pkg::ST_PKI;
            end
            csp_pkg::ST_PKI: begin
                o_cmd.op = csp_pkg::OP_PKI;
                n_state  = csp_pkg::ST_PSUM;
            end
            csp_pkg::ST_PSUM: begin
                o_cmd.op = csp_pkg::OP_PSUM;
                n_state  = csp_pkg::ST_ABS;
            end
            csp_pkg::ST_ABS: begin
                o_cmd.op = csp_pkg::OP_ABS;
                n_state  = csp_pkg::ST_TGT;
            end
            csp_pkg::ST_TGT: begin
                o_cmd.op = csp_pkg::OP_TGT;
                n_state  = csp_pkg::ST_E;
            end
            csp_pkg::ST_E: begin
                // demand within half an rpm leaves the speed loop alone
                if (i_status.run) begin
                    o_cmd.op = csp_pkg::OP_E;
                    n_state  = csp_pkg::ST_SKP;
                end else begin
                    n_state  = csp_pkg::ST_DONE;
                end
            end
            csp_pkg::ST_SKP: begin
                o_cmd.op = csp_pkg::OP_SKP;
                n_state  = csp_pkg::ST_SKI;
            end
            csp_pkg::ST_SKI: begin
                o_cmd.op = csp_pkg::OP_SKI;
                n_state  = csp_pkg::ST_SKD;
            end
            csp_pkg::ST_SKD: begin
                o_cmd.op = csp_pkg::OP_SKD;
                n_state  = csp_pkg::ST_SACC;
            end
            csp_pkg::ST_SACC: begin
                o_cmd.op = csp_pkg::OP_SACC;
                n_state  = csp_pkg::ST_DUTY;
            end
            csp_pkg::ST_DUTY: begin
                o_cmd.op = csp_pkg::OP_DUTY;
                n_state  = csp_pkg::ST_DONE;
            end
            csp_pkg::ST_DONE: begin
                // wait for the output register to be free
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = csp_pkg::ST_IDLE;
                end
            end
        endcase
    end

    assign o_in_stall  = (r_state != csp_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == csp_pkg::ST_DIFF))
        else $error("accepted word did not start the sequence");

    a_dead_skips: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == csp_pkg::ST_PINT && i_status.dead) |=> (r_state == csp_pkg::ST_DONE))
        else $error("deadband did not skip the loop steps");

    a_done_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == csp_pkg::ST_DONE && !(r_out_valid && i_out_stall))
        |=> (r_out_valid && r_state == csp_pkg::ST_IDLE))
        else $error("finished word not placed in the output register");

endmodule

@@ hw/rtl/cascaded_position_speed_pid.sv @@
// top level of the cascaded position/speed servo controller
//
//  channel   direction  handshake                  payload
//  in        input      i_in_valid / o_in_stall    i_encoder_count
//  out       output     o_out_valid / i_out_stall  o_pwm_duty, o_dir_a, o_dir_b,
//                                                  o_position_now, o_speed_now,
//                                                  o_speed_target, o_in_deadband
//  cfg       input      i_cfg_we                   i_cfg_idx, i_cfg_data
//
// a word runs every step on the full path, skips the speed loop steps when the
// demand is within half an rpm, and inside the deadband skips every step after
// the position integral; the step sequencer drives one shared 25x33 multiplier
// o_in_stall is high while a word is being worked on and while its result waits
// a stalled result sits in the output register; the next word may be accepted meanwhile
// synchronous active-low reset restores the register defaults and clears the loop state
module cascaded_position_speed_pid (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [csp_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [csp_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [csp_pkg::CNT_W-1:0]         i_encoder_count,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [csp_pkg::DUTY_W-1:0]        o_pwm_duty,
    output logic                              o_dir_a,
    output logic                              o_dir_b,
    output logic signed [csp_pkg::POS_W-1:0]  o_position_now,
    output logic signed [csp_pkg::SPD_W-1:0]  o_speed_now,
    output logic signed [csp_pkg::TGT_W-1:0]  o_speed_target,
    output logic                              o_in_deadband
);

    localparam logic [csp_pkg::DUTY_W-1:0] DUTY_OFF = '0;

    csp_pkg::t_cmd    cmd;
    csp_pkg::t_status status;

    csp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    csp_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_encoder_count (i_encoder_count),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_pwm_duty      (o_pwm_duty),
        .o_dir_a         (o_dir_a),
        .o_dir_b         (o_dir_b),
        .o_position_now  (o_position_now),
        .o_speed_now     (o_speed_now),
        .o_speed_target  (o_speed_target),
        .o_in_deadband   (o_in_deadband)
    );

    a_dead_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_in_deadband) |-> (o_pwm_duty == DUTY_OFF))
        else $error("duty not zero inside deadband");

    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_pwm_duty == DUTY_OFF
                         || (o_pwm_duty >= csp_pkg::DUTY_MIN
                             && o_pwm_duty <= csp_pkg::DUTY_MAX)))
        else $error("duty outside its clamp range");

    a_dir_opposite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_dir_a != o_dir_b))
        else $error("direction pins not complementary");

endmodule
